>>> rtl/set_assoc_lru_cache_controller_top_defines.svh
// Assertion macros for the cache controller RTL.
// Included by files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef SET_ASSOC_LRU_CACHE_CONTROLLER_TOP_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_CONTROLLER_TOP_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define SALC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a signal holds in the cycle after a condition.
`define SALC_ASSERT_HOLD(lbl, cond, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
    else $error(msg);

`endif

>>> rtl/salc_pkg.sv
// Shared types and constants of the cache controller.
// No dependencies; used by the interfaces, the lookup logic and the top level.
`default_nettype none

package salc_pkg;

  localparam int ADDR_W     = 32;
  localparam int WAY_IDX_W  = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_WT_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WA_MODE = 1'd1;

  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  typedef struct packed {
    logic wt_en;
    logic wa_en;
  } mode_t;

  typedef struct packed {
    logic state_we;
    logic tag_we;
  } upd_t;

  typedef struct packed {
    logic                 hit;
    logic [WAY_IDX_W-1:0] way_index;
    logic                 fill_needed;
    logic [ADDR_W-1:0]    fill_address;
    logic                 writeback_needed;
    logic [ADDR_W-1:0]    writeback_address;
    logic                 write_forward;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/salc_if.sv
// Request and result channel interfaces of the cache controller.
// Depends on salc_pkg for field widths.
`default_nettype none

interface salc_req_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [salc_pkg::ADDR_W-1:0] address;

  modport source (output valid, output kind, output address, input ready);
  modport sink   (input valid, input kind, input address, output ready);
endinterface

interface salc_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic [salc_pkg::WAY_IDX_W-1:0] way_index;
  logic                          fill_needed;
  logic [salc_pkg::ADDR_W-1:0]    fill_address;
  logic                          writeback_needed;
  logic [salc_pkg::ADDR_W-1:0]    writeback_address;
  logic                          write_forward;

  modport source (output valid, output hit, output way_index, output fill_needed,
                  output fill_address, output writeback_needed,
                  output writeback_address, output write_forward, input ready);
  modport sink   (input valid, input hit, input way_index, input fill_needed,
                  input fill_address, input writeback_needed,
                  input writeback_address, input write_forward, output ready);
endinterface

`default_nettype wire

>>> rtl/set_assoc_lru_cache_controller_top.sv
// Set-associative cache controller: tag, valid, dirty and true-LRU bookkeeping,
// write-back or write-through, with or without write allocation. Requests are
// taken at one per cycle sustained, and a stalled output holds the pipeline;
// each result passes through a registered read of the set row, then the
// compare and update into the output register.
// One row per set lives in a tag memory and a state memory (valid, dirty and
// recency order); a request that hits the set written by the one just before
// it takes that row from a forwarding register. After reset the state memory
// is cleared one set per cycle while no request is accepted; configuration
// writes are taken throughout.
// Depends on salc_pkg, salc_if, salc_ram, salc_lookup and the defines header.
`default_nettype none
`include "set_assoc_lru_cache_controller_top_defines.svh"

module set_assoc_lru_cache_controller_top #(
  parameter int SETS        = 64,
  parameter int WAYS        = 4,
  parameter int BLOCK_BYTES = 64,
  parameter int ADDR_BITS   = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  salc_req_if.sink                              in_ch,
  salc_rsp_if.source                            out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [salc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [salc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int AW_ = salc_pkg::ADDR_W;
  localparam int OB      = $clog2(BLOCK_BYTES + 1) - 1;
  localparam int SB      = $clog2(SETS + 1) - 1;
  localparam int LOWB    = OB + SB;
  localparam int TAG_RAW = (ADDR_BITS > LOWB) ? ADDR_BITS - LOWB : 0;
  localparam int TAGW    = (TAG_RAW > 0) ? TAG_RAW : 1;
  localparam int WB      = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int AW      = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int STW     = WAYS * (2 + WB);
  localparam int TRW     = WAYS * TAGW;

  localparam logic [AW_-1:0] AMASK = (ADDR_BITS >= AW_) ? '1 :
                                     AW_'((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [AW_-1:0] OMASK = AW_'((64'd1 << OB) - 64'd1);
  localparam logic [AW_-1:0] SMASK = AW_'((64'd1 << SB) - 64'd1);
  localparam logic [63:0]    TMASK = (TAG_RAW >= 64) ? '1 : (64'd1 << TAG_RAW) - 64'd1;
  localparam logic [AW-1:0]  LAST_SET = AW'(SETS - 1);

  typedef enum logic {ST_CLEAR, ST_RUN} state_t;

  state_t            state_r;
  logic [AW-1:0]     clr_cnt_r;
  logic              s1_valid_r;
  logic              out_valid_r;
  logic              fwd_valid_r;
  salc_pkg::mode_t   mode_r;
  logic              s1_kind_r;
  logic [AW_-1:0]    s1_addr_r;
  logic [AW-1:0]     fwd_set_r;
  logic [STW-1:0]    fwd_st_r;
  logic [TRW-1:0]    fwd_tag_r;
  salc_pkg::result_t out_res_r;

  logic              in_ready;
  logic              in_fire;
  logic              s1_adv;
  logic              s1_fire;
  logic [AW_-1:0]    in_addr_m;
  logic [AW-1:0]     in_set;
  logic [AW-1:0]     s1_set;
  logic [TAGW-1:0]   s1_tag;
  logic [AW_-1:0]    s1_fill_addr;
  logic [STW-1:0]    st_rdata;
  logic [TRW-1:0]    tag_rdata;
  logic [STW-1:0]    st_row;
  logic [TRW-1:0]    tag_row;
  logic [STW-1:0]    st_row_nxt;
  logic [TRW-1:0]    tag_row_nxt;
  logic [STW-1:0]    clr_row;
  logic [STW-1:0]    st_wdata;
  logic [AW-1:0]     st_waddr;
  logic              st_we;
  logic              fwd_hit;
  salc_pkg::upd_t    upd;
  salc_pkg::result_t res;

  assign s1_adv   = !out_valid_r || out_ch.ready;
  assign in_ready = (state_r == ST_RUN) && (!s1_valid_r || s1_adv);
  assign in_fire  = in_ready && in_ch.valid;
  assign s1_fire  = s1_valid_r && s1_adv;

  assign in_addr_m    = in_ch.address & AMASK;
  assign in_set       = AW'((in_addr_m >> OB) & SMASK);
  assign s1_set       = AW'((s1_addr_r >> OB) & SMASK);
  assign s1_tag       = TAGW'((64'(s1_addr_r) >> LOWB) & TMASK);
  assign s1_fill_addr = s1_addr_r & ~OMASK;

  always_comb begin
    clr_row = '0;
    for (int p = 0; p < WAYS; p++) begin
      clr_row[2*WAYS + p*WB +: WB] = WB'(p);
    end
  end

  assign fwd_hit  = fwd_valid_r && (fwd_set_r == s1_set);
  assign st_row   = fwd_hit ? fwd_st_r : st_rdata;
  assign tag_row  = fwd_hit ? fwd_tag_r : tag_rdata;
  assign st_we    = (state_r == ST_CLEAR) || (s1_fire && upd.state_we);
  assign st_waddr = (state_r == ST_CLEAR) ? clr_cnt_r : s1_set;
  assign st_wdata = (state_r == ST_CLEAR) ? clr_row : st_row_nxt;

  salc_ram #(.WIDTH(STW), .DEPTH(SETS)) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (in_fire),
    .raddr (in_set),
    .rdata (st_rdata)
  );

  salc_ram #(.WIDTH(TRW), .DEPTH(SETS)) u_tag_ram (
    .clk   (clk),
    .we    (s1_fire && upd.tag_we),
    .waddr (s1_set),
    .wdata (tag_row_nxt),
    .re    (in_fire),
    .raddr (in_set),
    .rdata (tag_rdata)
  );

  salc_lookup #(
    .WAYS (WAYS),
    .WB   (WB),
    .TAGW (TAGW),
    .AW   (AW),
    .OB   (OB),
    .LOWB (LOWB)
  ) u_lookup (
    .mode          (mode_r),
    .kind          (s1_kind_r),
    .fill_addr     (s1_fill_addr),
    .set           (s1_set),
    .tag           (s1_tag),
    .tag_row       (tag_row),
    .state_row     (st_row),
    .tag_row_nxt   (tag_row_nxt),
    .state_row_nxt (st_row_nxt),
    .upd           (upd),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_valid_r <= 1'b0;
      mode_r      <= '{wt_en: 1'b0, wa_en: 1'b1};
    end else begin
      unique case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + AW'(1);
          if (clr_cnt_r == LAST_SET) begin
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          state_r <= ST_RUN;
        end
        default: state_r <= ST_CLEAR;
      endcase
      if (in_ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_fire && upd.state_we) begin
        fwd_valid_r <= 1'b1;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          salc_pkg::CFG_WT_MODE: mode_r.wt_en <= cfg_wdata[0];
          salc_pkg::CFG_WA_MODE: mode_r.wa_en <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind_r <= in_ch.kind;
      s1_addr_r <= in_addr_m;
    end
    if (s1_fire && upd.state_we) begin
      fwd_set_r <= s1_set;
      fwd_st_r  <= st_row_nxt;
      fwd_tag_r <= tag_row_nxt;
    end
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  assign in_ch.ready              = in_ready;
  assign out_ch.valid             = out_valid_r;
  assign out_ch.hit               = out_res_r.hit;
  assign out_ch.way_index         = out_res_r.way_index;
  assign out_ch.fill_needed       = out_res_r.fill_needed;
  assign out_ch.fill_address      = out_res_r.fill_address;
  assign out_ch.writeback_needed  = out_res_r.writeback_needed;
  assign out_ch.writeback_address = out_res_r.writeback_address;
  assign out_ch.write_forward     = out_res_r.write_forward;

  `SALC_ASSERT(a_wb_needs_fill,
               out_valid_r && out_res_r.writeback_needed |-> out_res_r.fill_needed,
               "writeback without fill")
  `SALC_ASSERT(a_hit_no_fill, out_valid_r && out_res_r.hit |-> !out_res_r.fill_needed,
               "fill on a hit")
  `SALC_ASSERT(a_clear_idle, state_r == ST_CLEAR |-> !s1_valid_r && !in_ready,
               "request during clear")
  `SALC_ASSERT_HOLD(a_stall_hold, s1_valid_r && !s1_adv, s1_addr_r, "stalled request changed")

endmodule

`default_nettype wire

>>> rtl/salc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> rtl/salc_lookup.sv
// Tag compare, LRU victim choice and row update for one set.
// Depends on salc_pkg for the mode, update and result types.
`default_nettype none

module salc_lookup #(
  parameter int WAYS = 4,
  parameter int WB   = 2,
  parameter int TAGW = 20,
  parameter int AW   = 6,
  parameter int OB   = 6,
  parameter int LOWB = 12
) (
  input  wire salc_pkg::mode_t           mode,
  input  wire logic                      kind,
  input  wire logic [salc_pkg::ADDR_W-1:0] fill_addr,
  input  wire logic [AW-1:0]             set,
  input  wire logic [TAGW-1:0]           tag,
  input  wire logic [WAYS*TAGW-1:0]      tag_row,
  input  wire logic [WAYS*(2+WB)-1:0]    state_row,
  output logic      [WAYS*TAGW-1:0]      tag_row_nxt,
  output logic      [WAYS*(2+WB)-1:0]    state_row_nxt,
  output salc_pkg::upd_t                 upd,
  output salc_pkg::result_t              res
);

  logic [TAGW-1:0] tags     [WAYS];
  logic [TAGW-1:0] tags_n   [WAYS];
  logic [WB-1:0]   order    [WAYS];
  logic [WB-1:0]   order_n  [WAYS];
  logic [WAYS-1:0] valid;
  logic [WAYS-1:0] dirty;
  logic [WAYS-1:0] valid_n;
  logic [WAYS-1:0] dirty_n;
  logic [WAYS-1:0] hit_vec;
  logic [WB-1:0]   hit_way;
  logic [WB-1:0]   victim;
  logic [WB-1:0]   way;
  logic [WB-1:0]   pos;
  logic            hit;
  logic            is_write;
  logic            bypass;
  logic [63:0]     wb_addr;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      tags[w]  = tag_row[w*TAGW +: TAGW];
      valid[w] = state_row[w];
      dirty[w] = state_row[WAYS + w];
      order[w] = state_row[2*WAYS + w*WB +: WB];
      hit_vec[w] = valid[w] && (tags[w] == tag);
    end
    hit_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (hit_vec[w]) begin
        hit_way = WB'(w);
      end
    end
    hit      = |hit_vec;
    is_write = (kind == salc_pkg::KIND_WRITE);
    bypass   = !hit && is_write && !mode.wa_en;
    victim   = order[WAYS-1];
    way      = hit ? hit_way : (bypass ? '0 : victim);

    pos = WB'(WAYS - 1);
    if (hit) begin
      for (int p = 0; p < WAYS; p++) begin
        if (order[p] == hit_way) begin
          pos = WB'(p);
        end
      end
    end
    order_n[0] = way;
    for (int i = 1; i < WAYS; i++) begin
      order_n[i] = (WB'(i) <= pos) ? order[i-1] : order[i];
    end

    valid_n = valid;
    dirty_n = dirty;
    for (int w = 0; w < WAYS; w++) begin
      tags_n[w] = tags[w];
    end
    wb_addr = 64'(tags[victim]) << LOWB | (64'(set) << OB);

    res              = '0;
    res.hit          = hit;
    res.way_index    = salc_pkg::WAY_IDX_W'(way);
    upd.state_we     = !bypass;
    upd.tag_we       = !hit && !bypass;
    if (hit) begin
      res.write_forward = is_write && mode.wt_en;
      if (is_write && !mode.wt_en) begin
        dirty_n[hit_way] = 1'b1;
      end
    end else if (bypass) begin
      res.write_forward = 1'b1;
    end else begin
      res.fill_needed      = 1'b1;
      res.fill_address     = fill_addr;
      res.writeback_needed = !mode.wt_en && dirty[victim];
      if (!mode.wt_en && dirty[victim]) begin
        res.writeback_address = wb_addr[salc_pkg::ADDR_W-1:0];
      end
      res.write_forward = is_write && mode.wt_en;
      valid_n[victim]   = 1'b1;
      dirty_n[victim]   = is_write && !mode.wt_en;
      tags_n[victim]    = tag;
    end

    for (int w = 0; w < WAYS; w++) begin
      tag_row_nxt[w*TAGW +: TAGW]            = tags_n[w];
      state_row_nxt[w]                       = valid_n[w];
      state_row_nxt[WAYS + w]                = dirty_n[w];
      state_row_nxt[2*WAYS + w*WB +: WB]     = order_n[w];
    end
  end

endmodule

`default_nettype wire
